[sv/slr_pkg.sv]
// Shared types, codes and constant tables for the styled line rasterizer.
package slr_pkg;

	// Fixed field widths
	localparam int OPCODE_BITS    = 3;
	localparam int STYLE_BITS     = 3;
	localparam int PATTERN_BITS   = 16;
	localparam int COLOR_BITS     = 4;
	localparam int SCREEN_BITS    = 16;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int PATTERN_SEL_BITS = 4;

	// Command queue depth between front and back
	localparam int QUEUE_DEPTH = 4;

	// Configuration reset values
	localparam logic [STYLE_BITS-1:0]   STYLE_RESET   = 3'd0;
	localparam logic [PATTERN_BITS-1:0] PATTERN_RESET = 16'hFFFF;
	localparam logic [COLOR_BITS-1:0]   COLOR_RESET   = 4'd15;
	localparam logic [SCREEN_BITS-1:0]  WIDTH_RESET   = 16'd640;
	localparam logic [SCREEN_BITS-1:0]  HEIGHT_RESET  = 16'd400;

	// Built-in dash patterns
	localparam logic [PATTERN_BITS-1:0] PAT_SOLID  = 16'hFFFF;
	localparam logic [PATTERN_BITS-1:0] PAT_DOTTED = 16'hCCCC;
	localparam logic [PATTERN_BITS-1:0] PAT_CENTER = 16'hF8F8;
	localparam logic [PATTERN_BITS-1:0] PAT_DASHED = 16'hF0F0;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_LINE     = 3'd0,
		OP_LINE_TO  = 3'd1,
		OP_LINE_REL = 3'd2,
		OP_MOVE_PEN = 3'd3,
		OP_STEP     = 3'd4
	} op_t;

	typedef enum logic [STYLE_BITS-1:0] {
		STYLE_SOLID  = 3'd0,
		STYLE_DOTTED = 3'd1,
		STYLE_CENTER = 3'd2,
		STYLE_DASHED = 3'd3,
		STYLE_USER   = 3'd4
	} style_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DASH_STYLE    = 3'd0,
		REG_USER_PATTERN  = 3'd1,
		REG_DRAW_COLOR    = 3'd2,
		REG_SCREEN_WIDTH  = 3'd3,
		REG_SCREEN_HEIGHT = 3'd4
	} cfg_reg_t;

	// Kind of entry in the command queue
	typedef enum logic {
		CMD_BEGIN = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic [STYLE_BITS-1:0]   dash_style;
		logic [PATTERN_BITS-1:0] user_pattern;
		logic [COLOR_BITS-1:0]   draw_color;
		logic [SCREEN_BITS-1:0]  screen_width;
		logic [SCREEN_BITS-1:0]  screen_height;
	} cfg_t;

	// Select the active dash pattern
	function automatic logic [PATTERN_BITS-1:0] style_pattern(
		input logic [STYLE_BITS-1:0]   style,
		input logic [PATTERN_BITS-1:0] user
	);
		logic [PATTERN_BITS-1:0] pat;
		case (style_t'(style))
			STYLE_DOTTED: pat = PAT_DOTTED;
			STYLE_CENTER: pat = PAT_CENTER;
			STYLE_DASHED: pat = PAT_DASHED;
			STYLE_USER:   pat = user;
			default:      pat = PAT_SOLID;
		endcase
		return pat;
	endfunction

	// Map logical color to device color
	function automatic logic [COLOR_BITS-1:0] color_map(input logic [COLOR_BITS-1:0] c);
		logic [COLOR_BITS-1:0] d;
		case (c)
			4'd0:    d = 4'd0;
			4'd1:    d = 4'd9;
			4'd2:    d = 4'd13;
			4'd3:    d = 4'd14;
			4'd4:    d = 4'd12;
			4'd5:    d = 4'd6;
			4'd6:    d = 4'd4;
			4'd7:    d = 4'd8;
			4'd8:    d = 4'd15;
			4'd9:    d = 4'd11;
			4'd10:   d = 4'd3;
			4'd11:   d = 4'd7;
			4'd12:   d = 4'd2;
			4'd13:   d = 4'd5;
			4'd14:   d = 4'd10;
			default: d = 4'd1;
		endcase
		return d;
	endfunction

endpackage

[sv/slr_front.sv]
// Front end: accepts items, tracks the pen and prepares line setup for the queue.
module slr_front import slr_pkg::*; #(
	parameter int COORD_BITS = 16,
	localparam int ENTRY_BITS = 7 * COORD_BITS + 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [OPCODE_BITS-1:0]       opcode,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         push_valid,
	input  logic                         push_ready,
	output logic [ENTRY_BITS-1:0]        push_data
);

	localparam int SW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;

	logic signed [COORD_BITS-1:0] pen_x_q, pen_y_q;
	logic                         valid_s1;
	cmd_kind_t                    kind_s1;
	logic signed [COORD_BITS-1:0] x1_s1, y1_s1, x2_s1, y2_s1;

	logic                         in_fire;
	logic                         load;
	logic                         pen_we;
	cmd_kind_t                    kind_d;
	logic signed [COORD_BITS-1:0] x1_d, y1_d, x2_d, y2_d;
	logic signed [COORD_BITS-1:0] pen_x_d, pen_y_d;
	logic signed [COORD_BITS-1:0] rel_x, rel_y;

	assign in_ready = !valid_s1 || push_ready;
	assign in_fire  = in_valid && in_ready;
	assign rel_x    = pen_x_q + end_x;
	assign rel_y    = pen_y_q + end_y;

	// Decode the opcode into line endpoints and pen updates
	always_comb begin
		load    = 1'b0;
		pen_we  = 1'b0;
		kind_d  = CMD_BEGIN;
		x1_d    = start_x;
		y1_d    = start_y;
		x2_d    = end_x;
		y2_d    = end_y;
		pen_x_d = end_x;
		pen_y_d = end_y;
		case (op_t'(opcode))
			OP_LINE: begin
				load = 1'b1;
			end
			OP_LINE_TO: begin
				load   = 1'b1;
				pen_we = 1'b1;
				x1_d   = pen_x_q;
				y1_d   = pen_y_q;
			end
			OP_LINE_REL: begin
				load    = 1'b1;
				pen_we  = 1'b1;
				x1_d    = pen_x_q;
				y1_d    = pen_y_q;
				x2_d    = rel_x;
				y2_d    = rel_y;
				pen_x_d = rel_x;
				pen_y_d = rel_y;
			end
			OP_MOVE_PEN: begin
				pen_we = 1'b1;
			end
			OP_STEP: begin
				load   = 1'b1;
				kind_d = CMD_STEP;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Hold the pen and the decoded stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_fire && pen_we) begin
				pen_x_q <= pen_x_d;
				pen_y_q <= pen_y_d;
			end
			if (in_ready) begin
				valid_s1 <= in_fire && load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && load) begin
			kind_s1 <= kind_d;
			x1_s1   <= x1_d;
			y1_s1   <= y1_d;
			x2_s1   <= x2_d;
			y2_s1   <= y2_d;
		end
	end

	// Compute spans, directions and the initial error term
	logic signed [SW-1:0] x1e, y1e, x2e, y2e;
	logic                 gt_x, gt_y;
	logic [SW-1:0]        span_x, span_y;
	logic signed [EW-1:0] err0;

	always_comb begin
		x1e    = SW'(x1_s1);
		y1e    = SW'(y1_s1);
		x2e    = SW'(x2_s1);
		y2e    = SW'(y2_s1);
		gt_x   = x2_s1 > x1_s1;
		gt_y   = y2_s1 > y1_s1;
		span_x = gt_x ? SW'(x2e - x1e) : SW'(x1e - x2e);
		span_y = gt_y ? SW'(y2e - y1e) : SW'(y1e - y2e);
		err0   = $signed(EW'(span_x)) - $signed(EW'(span_y));
	end

	assign push_valid = valid_s1;
	assign push_data  = {kind_s1, x1_s1, y1_s1, x2_s1, y2_s1, span_x, span_y, err0,
		!gt_x, !gt_y};

endmodule

[sv/slr_queue.sv]
// Short command queue that decouples the front end from the line walker.
module slr_queue import slr_pkg::*; #(
	parameter int WIDTH = 120
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] fifo_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;
	logic             push, pop;

	assign push_ready = count_q != (PW + 1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = fifo_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Write the incoming beat at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW + 1)'(QUEUE_DEPTH))
		else $error("queue occupancy above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue occupancy did not grow on push");

endmodule

[sv/slr_back.sv]
// Line walker: runs Bresenham steps, applies style, clipping and color, registers results.
module slr_back import slr_pkg::*; #(
	parameter int COORD_BITS     = 16,
	parameter int PATTERN_LENGTH = 16,
	localparam int ENTRY_BITS = 7 * COORD_BITS + 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  logic [ENTRY_BITS-1:0]        pop_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic                         plot,
	output logic [COLOR_BITS-1:0]        device_color,
	output logic                         last_point
);

	localparam int SW   = COORD_BITS + 1;
	localparam int EW   = COORD_BITS + 3;
	localparam int XW   = COORD_BITS + 4;
	localparam int PIW  = $clog2(PATTERN_LENGTH);
	localparam int CMPW = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

	// Unpack the queue entry
	cmd_kind_t                    e_kind;
	logic signed [COORD_BITS-1:0] e_wx, e_wy, e_tx, e_ty;
	logic [SW-1:0]                e_sx, e_sy;
	logic signed [EW-1:0]         e_err;
	logic                         e_dxn, e_dyn;

	assign e_kind = cmd_kind_t'(pop_data[ENTRY_BITS-1]);
	assign {e_wx, e_wy, e_tx, e_ty, e_sx, e_sy, e_err, e_dxn, e_dyn} =
		pop_data[ENTRY_BITS-2:0];

	// Line state
	logic                         active_q;
	logic signed [COORD_BITS-1:0] walk_x_q, walk_y_q, target_x_q, target_y_q;
	logic [SW-1:0]                span_x_q, span_y_q;
	logic signed [EW-1:0]         err_q;
	logic                         dxn_q, dyn_q;
	logic [PIW-1:0]               pidx_q;

	// Output register
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] point_x_q, point_y_q;
	logic                         plot_q, last_q;
	logic [COLOR_BITS-1:0]        color_q;

	logic pop, do_begin, do_step;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;
	assign do_begin  = pop && (e_kind == CMD_BEGIN);
	assign do_step   = pop && (e_kind == CMD_STEP) && active_q;

	// Evaluate the current point and the next Bresenham move
	logic signed [XW-1:0]         e2, sx_ext, sy_ext, err_next;
	logic                         move_x, move_y, is_last, on_screen, pat_bit;
	logic [PATTERN_BITS-1:0]      pattern;
	logic [PATTERN_SEL_BITS-1:0]  pat_sel;
	logic [PIW-1:0]               pidx_next;
	logic signed [COORD_BITS-1:0] walk_x_next, walk_y_next;

	always_comb begin
		e2        = XW'(err_q) <<< 1;
		sx_ext    = $signed(XW'(span_x_q));
		sy_ext    = $signed(XW'(span_y_q));
		move_x    = e2 > -sy_ext;
		move_y    = e2 < sx_ext;
		err_next  = XW'(err_q) - (move_x ? sy_ext : '0) + (move_y ? sx_ext : '0);
		walk_x_next = move_x ? (dxn_q ? walk_x_q - 1'b1 : walk_x_q + 1'b1) : walk_x_q;
		walk_y_next = move_y ? (dyn_q ? walk_y_q - 1'b1 : walk_y_q + 1'b1) : walk_y_q;
		pidx_next = (pidx_q == PIW'(PATTERN_LENGTH - 1)) ? '0 : pidx_q + 1'b1;
		is_last   = (walk_x_q == target_x_q) && (walk_y_q == target_y_q);
		on_screen = !walk_x_q[COORD_BITS-1] && !walk_y_q[COORD_BITS-1]
			&& (CMPW'($unsigned(walk_x_q)) < CMPW'(cfg.screen_width))
			&& (CMPW'($unsigned(walk_y_q)) < CMPW'(cfg.screen_height));
		pattern   = style_pattern(cfg.dash_style, cfg.user_pattern);
		pat_sel   = PATTERN_SEL_BITS'(pidx_q);
		pat_bit   = pattern[pat_sel];
	end

	// Load a new line or advance the one in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			walk_x_q   <= '0;
			walk_y_q   <= '0;
			target_x_q <= '0;
			target_y_q <= '0;
			span_x_q   <= '0;
			span_y_q   <= '0;
			err_q      <= '0;
			dxn_q      <= 1'b0;
			dyn_q      <= 1'b0;
			pidx_q     <= '0;
		end else if (do_begin) begin
			active_q   <= 1'b1;
			walk_x_q   <= e_wx;
			walk_y_q   <= e_wy;
			target_x_q <= e_tx;
			target_y_q <= e_ty;
			span_x_q   <= e_sx;
			span_y_q   <= e_sy;
			err_q      <= e_err;
			dxn_q      <= e_dxn;
			dyn_q      <= e_dyn;
			pidx_q     <= '0;
		end else if (do_step) begin
			if (is_last) begin
				active_q <= 1'b0;
			end else begin
				walk_x_q <= walk_x_next;
				walk_y_q <= walk_y_next;
				err_q    <= EW'(err_next);
				pidx_q   <= pidx_next;
			end
		end
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= do_step;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			point_x_q <= walk_x_q;
			point_y_q <= walk_y_q;
			plot_q    <= pat_bit && on_screen;
			color_q   <= color_map(cfg.draw_color);
			last_q    <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_x      = point_x_q;
	assign point_y      = point_y_q;
	assign plot         = plot_q;
	assign device_color = color_q;
	assign last_point   = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(active_q))
		else $error("result emitted with no line in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && is_last) |=> !active_q)
		else $error("line still active after its final point");

	assert property (@(posedge clk) disable iff (!arst_n)
		do_begin |=> (active_q && pidx_q == '0))
		else $error("new line did not restart the pattern");

endmodule

[sv/styled_line_rasterizer.sv]
// Styled line rasterizer: a Bresenham line generator with a repeating 16-bit dash
// pattern, screen clipping and a fixed color map. Command beats start a line (absolute,
// from the pen, or relative to the pen) or move the pen; each step beat emits one point
// of the line in progress, and the final point carries last_point. A step while no line
// is active produces nothing, and a new line command drops any line in progress. The
// block sustains one item per clock on both command and step beats while the result side
// is not stalled: the walker does one Bresenham iteration per cycle, and a four-entry
// command queue between the input decoder and the walker lets either side stall on its
// own. An accepted step beat passes through the decode stage register, the queue and
// the result register, each of which can stall. Configuration registers are always ready
// and are to be written only while the block is idle. No clearing pass follows reset.
module styled_line_rasterizer import slr_pkg::*; #(
	parameter int COORD_BITS     = 16,
	parameter int PATTERN_LENGTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [OPCODE_BITS-1:0]       opcode,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic                         plot,
	output logic [COLOR_BITS-1:0]        device_color,
	output logic                         last_point
);

	localparam int ENTRY_BITS = 7 * COORD_BITS + 8;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	// Write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dash_style    <= STYLE_RESET;
			cfg_q.user_pattern  <= PATTERN_RESET;
			cfg_q.draw_color    <= COLOR_RESET;
			cfg_q.screen_width  <= WIDTH_RESET;
			cfg_q.screen_height <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_DASH_STYLE:    cfg_q.dash_style    <= cfg_data[STYLE_BITS-1:0];
				REG_USER_PATTERN:  cfg_q.user_pattern  <= cfg_data[PATTERN_BITS-1:0];
				REG_DRAW_COLOR:    cfg_q.draw_color    <= cfg_data[COLOR_BITS-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[SCREEN_BITS-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[SCREEN_BITS-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	logic                  push_valid, push_ready, pop_valid, pop_ready;
	logic [ENTRY_BITS-1:0] push_data, pop_data;

	slr_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	slr_queue #(
		.WIDTH (ENTRY_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	slr_back #(
		.COORD_BITS     (COORD_BITS),
		.PATTERN_LENGTH (PATTERN_LENGTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.plot         (plot),
		.device_color (device_color),
		.last_point   (last_point)
	);

endmodule

[tb/sv/styled_line_rasterizer_tb.sv]
// Self-checking testbench for the styled line rasterizer with its own line-walk predictor.
`timescale 1ns / 100ps

module styled_line_rasterizer_tb import slr_pkg::*; ();

	localparam int CW = 16;
	localparam int PHASES = 12;
	localparam int PHASE_BEATS = 127;
	// Margin for the decode stage, the command queue and the result register; a command leaves no result behind
	localparam int SETTLE_CYCLES = 12;
	// Longest quiet stretch of a correct run is a receiver stall
	localparam int QUIET_LIMIT = 2000;
	localparam int REG_COUNT = 5;
	localparam logic [OPCODE_BITS-1:0] OP_UNUSED_LO = 3'd5;
	localparam logic [OPCODE_BITS-1:0] OP_UNUSED_HI = 3'd7;

	typedef logic signed [CW-1:0] coord_t;

	localparam coord_t COORD_MIN = 16'sh8000;
	localparam coord_t COORD_MAX = 16'sh7FFF;

	// Device color for each logical color, entry i at bits 4*i+3..4*i
	localparam logic [63:0] SHADE_TABLE = {
		4'd1, 4'd10, 4'd5, 4'd2, 4'd7, 4'd3, 4'd11, 4'd15,
		4'd8, 4'd4, 4'd6, 4'd12, 4'd14, 4'd13, 4'd9, 4'd0
	};

	typedef struct packed {
		coord_t                x;
		coord_t                y;
		logic                  plot;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} point_t;

	typedef enum {CHECK_MODEL, CHECK_FIXED, CHECK_SILENT} check_t;

	typedef struct {
		logic [OPCODE_BITS-1:0] op;
		coord_t                 sx;
		coord_t                 sy;
		coord_t                 ex;
		coord_t                 ey;
		check_t                 how;
		point_t                 fixed;
	} script_row_t;

	typedef struct {
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [CFG_DATA_BITS-1:0]  data;
	} reg_write_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [OPCODE_BITS-1:0]    opcode = '0;
	coord_t                    start_x = '0;
	coord_t                    start_y = '0;
	coord_t                    end_x = '0;
	coord_t                    end_y = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	coord_t                    point_x;
	coord_t                    point_y;
	logic                      plot;
	logic [COLOR_BITS-1:0]     device_color;
	logic                      last_point;

	// Predictor copy of the registers
	logic [STYLE_BITS-1:0]   cfg_style = STYLE_RESET;
	logic [PATTERN_BITS-1:0] cfg_pattern = PATTERN_RESET;
	logic [COLOR_BITS-1:0]   cfg_color = COLOR_RESET;
	logic [SCREEN_BITS-1:0]  cfg_width = WIDTH_RESET;
	logic [SCREEN_BITS-1:0]  cfg_height = HEIGHT_RESET;

	// Predictor copy of the pen and the line walker
	coord_t      pen_col = '0;
	coord_t      pen_row = '0;
	coord_t      cur_col = '0;
	coord_t      cur_row = '0;
	coord_t      dst_col = '0;
	coord_t      dst_row = '0;
	logic [16:0] run_x = '0;
	logic [16:0] run_y = '0;
	int          bres_err = 0;
	bit          x_back = 1'b0;
	bit          y_back = 1'b0;
	logic [3:0]  dash_pos = '0;
	bit          drawing = 1'b0;

	point_t      pending_points[$];
	script_row_t script[$];
	reg_write_t  reg_plan[$];
	point_t      got_want;
	int          mismatches = 0;
	int          beats_taken = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	bit          burst = 1'b0;

	styled_line_rasterizer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.plot         (plot),
		.device_color (device_color),
		.last_point   (last_point)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Open stretches with no idling on either side now and then
	initial begin
		forever begin
			repeat ($urandom_range(20, 80)) @(posedge clk);
			burst <= ($urandom_range(3) == 0);
		end
	end

	// Stall the result side at random
	always @(posedge clk) begin
		out_ready <= burst || ($urandom_range(99) >= recv_idle);
	end

	task automatic flag(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Compare each accepted point with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				flag($sformatf("unexpected point (%0d,%0d)", point_x, point_y));
			end else begin
				got_want = pending_points.pop_front();
				if (point_x !== got_want.x)
					flag($sformatf("point_x %0d, want %0d", point_x, got_want.x));
				if (point_y !== got_want.y)
					flag($sformatf("point_y %0d, want %0d", point_y, got_want.y));
				if (plot !== got_want.plot)
					flag($sformatf("plot %0b, want %0b at (%0d,%0d)", plot, got_want.plot,
						got_want.x, got_want.y));
				if (device_color !== got_want.color)
					flag($sformatf("device_color %0d, want %0d", device_color, got_want.color));
				if (last_point !== got_want.last)
					flag($sformatf("last_point %0b, want %0b at (%0d,%0d)", last_point,
						got_want.last, got_want.x, got_want.y));
			end
		end
	end

	// End the run when nothing moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic logic [PATTERN_BITS-1:0] dash_pattern();
		case (style_t'(cfg_style))
			STYLE_DOTTED: return PAT_DOTTED;
			STYLE_CENTER: return PAT_CENTER;
			STYLE_DASHED: return PAT_DASHED;
			STYLE_USER:   return cfg_pattern;
			default:      return PAT_SOLID;
		endcase
	endfunction

	task automatic start_walk(input coord_t x1, input coord_t y1, input coord_t x2,
			input coord_t y2);
		cur_col = x1;
		cur_row = y1;
		dst_col = x2;
		dst_row = y2;
		run_x = (x2 > x1) ? 17'(int'(x2) - int'(x1)) : 17'(int'(x1) - int'(x2));
		run_y = (y2 > y1) ? 17'(int'(y2) - int'(y1)) : 17'(int'(y1) - int'(y2));
		x_back = !(x1 < x2);
		y_back = !(y1 < y2);
		bres_err = int'(run_x) - int'(run_y);
		dash_pos = '0;
		drawing = 1'b1;
	endtask

	// Advance the predictor by one beat and return the point it emits, if any
	task automatic rasterize_beat(input logic [OPCODE_BITS-1:0] op, input coord_t sx,
			input coord_t sy, input coord_t ex, input coord_t ey, output bit emits,
			output point_t pt);
		coord_t                  nx;
		coord_t                  ny;
		logic [PATTERN_BITS-1:0] pat;
		bit                      seen;
		int                      e2;
		emits = 1'b0;
		pt = '0;
		case (op)
			OP_LINE: start_walk(sx, sy, ex, ey);
			OP_LINE_TO: begin
				start_walk(pen_col, pen_row, ex, ey);
				pen_col = ex;
				pen_row = ey;
			end
			OP_LINE_REL: begin
				nx = pen_col + ex;
				ny = pen_row + ey;
				start_walk(pen_col, pen_row, nx, ny);
				pen_col = nx;
				pen_row = ny;
			end
			OP_MOVE_PEN: begin
				pen_col = ex;
				pen_row = ey;
			end
			OP_STEP: begin
				if (drawing) begin
					pat = dash_pattern();
					seen = int'(cur_col) >= 0 && int'(cur_col) < int'(cfg_width) &&
						int'(cur_row) >= 0 && int'(cur_row) < int'(cfg_height);
					pt.x = cur_col;
					pt.y = cur_row;
					pt.plot = pat[dash_pos] && seen;
					pt.color = SHADE_TABLE[{cfg_color, 2'b00} +: 4];
					pt.last = (cur_col == dst_col) && (cur_row == dst_row);
					emits = 1'b1;
					if (pt.last) begin
						drawing = 1'b0;
					end else begin
						e2 = 2 * bres_err;
						if (e2 > -int'(run_y)) begin
							bres_err -= int'(run_y);
							cur_col = x_back ? cur_col - 16'sd1 : cur_col + 16'sd1;
						end
						if (e2 < int'(run_x)) begin
							bres_err += int'(run_x);
							cur_row = y_back ? cur_row - 16'sd1 : cur_row + 16'sd1;
						end
						dash_pos = dash_pos + 4'd1;
					end
				end
			end
			default: ;
		endcase
	endtask

	// Hand one beat to the block, then book what it should produce
	task automatic send_beat(input logic [OPCODE_BITS-1:0] op, input coord_t sx,
			input coord_t sy, input coord_t ex, input coord_t ey, input check_t how,
			input point_t fixed);
		int     gap;
		bit     emits;
		point_t pt;
		gap = 0;
		while (!burst && $urandom_range(99) < send_idle) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		rasterize_beat(op, sx, sy, ex, ey, emits, pt);
		if (how == CHECK_FIXED)
			pending_points.push_back(fixed);
		else if (how == CHECK_MODEL && emits)
			pending_points.push_back(pt);
		if (op <= OP_STEP) beats_taken++;
	endtask

	function automatic coord_t any_coord();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t near_screen();
		case ($urandom_range(7))
			0, 1:    return coord_t'($urandom_range(0, 40) - 20);
			2:       return coord_t'(int'(cfg_width) + $urandom_range(0, 20) - 10);
			3:       return coord_t'(int'(cfg_height) + $urandom_range(0, 20) - 10);
			4:       return any_coord();
			5:       return COORD_MIN + coord_t'($urandom_range(0, 10));
			6:       return COORD_MAX - coord_t'($urandom_range(0, 10));
			default: return coord_t'($urandom_range(0, 700));
		endcase
	endfunction

	// Mostly short spans; now and then a long one that gets cut off
	function automatic coord_t small_delta();
		if ($urandom_range(19) == 0) return any_coord();
		return coord_t'($urandom_range(0, 40) - 20);
	endfunction

	task automatic step_beat();
		send_beat(OP_STEP, any_coord(), any_coord(), any_coord(), any_coord(), CHECK_MODEL, '0);
	endtask

	task automatic add_row(input logic [OPCODE_BITS-1:0] op, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey, input check_t how, input point_t fixed);
		script_row_t row;
		row.op = op;
		row.sx = sx;
		row.sy = sy;
		row.ex = ex;
		row.ey = ey;
		row.how = how;
		row.fixed = fixed;
		script.push_back(row);
	endtask

	function automatic point_t mk_point(input coord_t x, input coord_t y, input logic p,
			input logic [COLOR_BITS-1:0] c, input logic l);
		point_t pt;
		pt.x = x;
		pt.y = y;
		pt.plot = p;
		pt.color = c;
		pt.last = l;
		return pt;
	endfunction

	// Drop the valid and wait until every expected point is out and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SCREEN_BITS-1:0] pick_size(input int k);
		case (k % 6)
			0:       return 16'd640;
			1:       return 16'd0;
			2:       return 16'd1;
			3:       return 16'd32768;
			4:       return 16'hFFFF;
			default: return 16'($urandom_range(1, 1000));
		endcase
	endfunction

	// Queue the register writes for one phase
	task automatic plan_settings(input int ph);
		reg_write_t w;
		w.idx = REG_DASH_STYLE;
		w.data = {13'($urandom), 3'(ph)};
		reg_plan.push_back(w);
		w.idx = REG_USER_PATTERN;
		w.data = (ph == 1) ? 16'h0000 : (ph == 2) ? 16'hFFFF : 16'($urandom);
		reg_plan.push_back(w);
		w.idx = REG_DRAW_COLOR;
		w.data = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : 16'($urandom);
		reg_plan.push_back(w);
		w.idx = REG_SCREEN_WIDTH;
		w.data = pick_size(ph);
		reg_plan.push_back(w);
		w.idx = REG_SCREEN_HEIGHT;
		w.data = pick_size(ph + 3);
		reg_plan.push_back(w);
		w.idx = 3'($urandom_range(REG_COUNT, 7));
		w.data = 16'($urandom);
		reg_plan.push_back(w);
	endtask

	// Write the queued registers back to back
	task automatic write_settings();
		reg_write_t w;
		while (reg_plan.size() != 0) begin
			w = reg_plan.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (w.idx)
				REG_DASH_STYLE:    cfg_style = w.data[STYLE_BITS-1:0];
				REG_USER_PATTERN:  cfg_pattern = w.data;
				REG_DRAW_COLOR:    cfg_color = w.data[COLOR_BITS-1:0];
				REG_SCREEN_WIDTH:  cfg_width = w.data;
				REG_SCREEN_HEIGHT: cfg_height = w.data;
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Random lines walked to their end, cut short or overrun, with some noise
	task automatic run_phase(input int quota);
		int                     first;
		int                     n;
		int                     i;
		int                     r;
		logic [OPCODE_BITS-1:0] op;
		coord_t                 sx;
		coord_t                 sy;
		first = beats_taken;
		while (beats_taken - first < quota) begin
			r = $urandom_range(99);
			if (r < 8) begin
				op = 3'($urandom_range(0, 7));
				send_beat(op, any_coord(), any_coord(), any_coord(), any_coord(), CHECK_MODEL, '0);
			end else begin
				if (r < 20)
					send_beat(OP_MOVE_PEN, any_coord(), any_coord(), near_screen(), near_screen(),
						CHECK_MODEL, '0);
				case ($urandom_range(2))
					0: begin
						sx = near_screen();
						sy = near_screen();
						send_beat(OP_LINE, sx, sy, sx + small_delta(), sy + small_delta(),
							CHECK_MODEL, '0);
					end
					1: send_beat(OP_LINE_TO, any_coord(), any_coord(), pen_col + small_delta(),
						pen_row + small_delta(), CHECK_MODEL, '0);
					default: send_beat(OP_LINE_REL, any_coord(), any_coord(), small_delta(),
						small_delta(), CHECK_MODEL, '0);
				endcase
				n = ((run_x > run_y) ? int'(run_x) : int'(run_y)) + 1;
				if (n > 40) n = $urandom_range(1, 30);
				r = $urandom_range(9);
				if (r == 0)
					n = n + $urandom_range(1, 3);
				else if (r == 1)
					n = $urandom_range(0, n - 1);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(49) == 0)
						send_beat(OP_MOVE_PEN, any_coord(), any_coord(), near_screen(),
							near_screen(), CHECK_MODEL, '0);
					step_beat();
				end
			end
		end
	endtask

	initial begin : stimulus
		int i;
		int ph;
		// Directed script: idle step, unused opcodes, one-point lines at the corners,
		// a line across the screen edge, relative wrap, pen moves and line drops
		add_row(OP_STEP, '0, '0, '0, '0, CHECK_SILENT, '0);
		add_row(OP_UNUSED_LO, COORD_MIN, COORD_MAX, -16'sd1, 16'sh5555, CHECK_SILENT, '0);
		add_row(OP_UNUSED_HI, COORD_MAX, COORD_MIN, 16'sh2AAA, -16'sd1, CHECK_SILENT, '0);
		add_row(OP_LINE, '0, '0, '0, '0, CHECK_MODEL, '0);
		add_row(OP_STEP, -16'sd1, -16'sd1, -16'sd1, -16'sd1, CHECK_FIXED,
			mk_point(16'sd0, 16'sd0, 1'b1, 4'd1, 1'b1));
		add_row(OP_STEP, '0, '0, '0, '0, CHECK_SILENT, '0);
		add_row(OP_LINE, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, CHECK_MODEL, '0);
		add_row(OP_STEP, '0, '0, '0, '0, CHECK_FIXED,
			mk_point(COORD_MIN, COORD_MAX, 1'b0, 4'd1, 1'b1));
		add_row(OP_LINE, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, CHECK_MODEL, '0);
		add_row(OP_STEP, '0, '0, '0, '0, CHECK_FIXED,
			mk_point(COORD_MAX, COORD_MIN, 1'b0, 4'd1, 1'b1));
		add_row(OP_LINE, 16'sd637, 16'sd397, 16'sd642, 16'sd399, CHECK_MODEL, '0);
		for (i = 0; i < 6; i++) add_row(OP_STEP, '0, '0, '0, '0, CHECK_MODEL, '0);
		add_row(OP_MOVE_PEN, '0, '0, COORD_MAX, COORD_MAX, CHECK_MODEL, '0);
		add_row(OP_LINE_REL, '0, '0, 16'sd1, 16'sd1, CHECK_MODEL, '0);
		add_row(OP_STEP, '0, '0, '0, '0, CHECK_MODEL, '0);
		add_row(OP_MOVE_PEN, '0, '0, 16'sd5, 16'sd5, CHECK_MODEL, '0);
		add_row(OP_STEP, '0, '0, '0, '0, CHECK_MODEL, '0);
		add_row(OP_LINE_TO, '0, '0, 16'sd8, 16'sd3, CHECK_MODEL, '0);
		add_row(OP_STEP, '0, '0, '0, '0, CHECK_MODEL, '0);
		add_row(OP_STEP, '0, '0, '0, '0, CHECK_MODEL, '0);

		// Hold reset, then release it
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 20;
		recv_idle = 77;
		for (i = 0; i < script.size(); i++)
			send_beat(script[i].op, script[i].sx, script[i].sy, script[i].ex, script[i].ey,
				script[i].how, script[i].fixed);
		settle();

		for (ph = 0; ph < PHASES; ph++) begin
			plan_settings(ph);
			write_settings();
			if (ph < PHASES / 3) begin
				send_idle = 20;
				recv_idle = 77;
			end else if (ph < 2 * PHASES / 3) begin
				send_idle = 77;
				recv_idle = 20;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			run_phase(PHASE_BEATS);
			settle();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
sv/slr_pkg.sv
sv/slr_front.sv
sv/slr_queue.sv
sv/slr_back.sv
sv/styled_line_rasterizer.sv
tb/sv/styled_line_rasterizer_tb.sv
